>>> hdl/ple_pkg.sv
// Shared types and constants for the positional list engine.
// Used by the controller, the datapath and the top level; depends on nothing.
package ple_pkg;

  localparam int CAPACITY  = 64;
  localparam int ADDR_W    = $clog2(CAPACITY);
  localparam int DATA_W    = 32;
  localparam int CNT_W     = 7;
  localparam int POS_W     = 7;
  localparam int OP_W      = 2;
  localparam int CNT_LIMIT = (CAPACITY < 127) ? CAPACITY : 127;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_READ   = 2'd2
  } op_t;

  typedef struct packed {
    logic load;
    logic init_k;
    logic mem_rd;
    logic wr_move;
    logic finish;
    logic reply;
    logic use_rdata;
  } ple_cmd_t;

  typedef struct packed {
    logic ok;
    logic more;
    logic is_read;
  } ple_stat_t;

endpackage

>>> hdl/positional_list_engine.sv
// Top level of the positional list engine: an ordered list of signed words.
// Depends on ple_pkg, ple_ctrl and ple_dp.
//
// A word is taken when start is high and busy is low; in_op selects insert,
// delete or read, in_position is the one-based place and in_value the word
// to insert. Every word gives exactly one result, shown for a single cycle
// with out_strobe high: out_status (0 success, 1 error), out_read_value (the
// word read, zero otherwise) and out_count (list length after the operation).
// The receiver cannot stall, so results must be taken as they appear.
// Busy stays high while a word is worked on: a rejected word only for the
// check, a read for the check and the RAM read, an insert or delete also
// for the element move. The result strobe comes in the first cycle in which
// busy is low again, and a new word may be started in that same cycle. The
// cost of insert and delete is the element move through the RAM, one
// element per RAM read and write.
// Reset clears the state machine, the count and the strobe; the list then
// holds no elements.
module positional_list_engine (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [ple_pkg::OP_W-1:0]          in_op,
  input  logic [ple_pkg::POS_W-1:0]         in_position,
  input  logic signed [ple_pkg::DATA_W-1:0] in_value,
  output logic                              out_strobe,
  output logic                              out_status,
  output logic signed [ple_pkg::DATA_W-1:0] out_read_value,
  output logic [ple_pkg::CNT_W-1:0]         out_count
);
  import ple_pkg::*;

  ple_cmd_t  cmd;
  ple_stat_t st;

  ple_ctrl u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .busy (busy),
    .st   (st),
    .cmd  (cmd)
  );

  ple_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .st            (st),
    .in_op         (in_op),
    .in_position   (in_position),
    .in_value      (in_value),
    .out_strobe    (out_strobe),
    .out_status    (out_status),
    .out_read_value(out_read_value),
    .out_count     (out_count)
  );

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result strobe while busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted word did not make the block busy");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status) |-> (out_read_value == '0))
    else $error("error result carries a nonzero read value");

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_count <= CNT_W'(CNT_LIMIT)))
    else $error("count above capacity");

endmodule

>>> hdl/ple_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; holds the list words for the datapath.
module ple_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/ple_ctrl.sv
// Controller state machine of the positional list engine.
// Depends on ple_pkg; drives the datapath through ple_cmd_t and reads ple_stat_t.
module ple_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  ple_pkg::ple_stat_t st,
  output ple_pkg::ple_cmd_t  cmd
);
  import ple_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CHECK = 5'b00010,
    S_LOOP  = 5'b00100,
    S_MOVE  = 5'b01000,
    S_RWAIT = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!st.ok) begin
          cmd.reply = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cmd.init_k = 1'b1;
          state_nxt  = S_LOOP;
        end
      end
      S_LOOP: begin
        if (st.is_read) begin
          cmd.mem_rd = 1'b1;
          state_nxt  = S_RWAIT;
        end else if (st.more) begin
          cmd.mem_rd = 1'b1;
          state_nxt  = S_MOVE;
        end else begin
          cmd.finish = 1'b1;
          cmd.reply  = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_MOVE: begin
        cmd.wr_move = 1'b1;
        state_nxt   = S_LOOP;
      end
      S_RWAIT: begin
        cmd.reply     = 1'b1;
        cmd.use_rdata = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

>>> hdl/ple_dp.sv
// Datapath of the positional list engine: operand registers, count, move index,
// the element RAM and the result registers. Depends on ple_pkg and ple_ram.
module ple_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  ple_pkg::ple_cmd_t                 cmd,
  output ple_pkg::ple_stat_t                st,
  input  logic [ple_pkg::OP_W-1:0]          in_op,
  input  logic [ple_pkg::POS_W-1:0]         in_position,
  input  logic signed [ple_pkg::DATA_W-1:0] in_value,
  output logic                              out_strobe,
  output logic                              out_status,
  output logic signed [ple_pkg::DATA_W-1:0] out_read_value,
  output logic [ple_pkg::CNT_W-1:0]         out_count
);
  import ple_pkg::*;

  logic [OP_W-1:0]   op_r;
  logic [POS_W-1:0]  pos_r;
  logic [DATA_W-1:0] val_r;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  k_r;
  logic              strobe_r;
  logic              status_r;
  logic [DATA_W-1:0] rdval_r;
  logic [CNT_W-1:0]  ocount_r;

  logic              is_ins, is_del, is_rd, ok;
  logic [POS_W-1:0]  pos_m1;
  logic [CNT_W-1:0]  k_m1;
  logic [CNT_W:0]    count_p1;
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [DATA_W-1:0] ram_wdata, ram_rdata;

  assign is_ins   = (op_r == OP_INSERT);
  assign is_del   = (op_r == OP_DELETE);
  assign is_rd    = (op_r == OP_READ);
  assign pos_m1   = pos_r - POS_W'(1);
  assign k_m1     = k_r - CNT_W'(1);
  assign count_p1 = {1'b0, count_r} + (CNT_W+1)'(1);

  always_comb begin
    ok = 1'b0;
    if (pos_r != '0) begin
      case (op_r)
        OP_INSERT: ok = ((CNT_W+1)'(pos_r) <= count_p1) &&
                        (count_r < CNT_W'(CNT_LIMIT));
        OP_DELETE, OP_READ: ok = (CNT_W'(pos_r) <= count_r);
        default: ok = 1'b0;
      endcase
    end
  end

  assign st.ok      = ok;
  assign st.is_read = is_rd;
  assign st.more    = is_ins ? (k_r >= CNT_W'(pos_r)) : (k_r < count_r);

  always_comb begin
    count_nxt = count_r;
    if (cmd.finish) begin
      if (is_ins) begin
        count_nxt = count_r + CNT_W'(1);
      end else if (is_del) begin
        count_nxt = count_r - CNT_W'(1);
      end
    end
  end

  assign ram_re    = cmd.mem_rd;
  assign ram_raddr = is_rd  ? ADDR_W'(pos_m1) :
                     is_ins ? ADDR_W'(k_m1) : ADDR_W'(k_r);
  assign ram_we    = cmd.wr_move || (cmd.finish && is_ins);
  assign ram_waddr = cmd.wr_move ? (is_ins ? ADDR_W'(k_r) : ADDR_W'(k_m1))
                                 : ADDR_W'(pos_m1);
  assign ram_wdata = cmd.wr_move ? ram_rdata : val_r;

  ple_ram #(
    .WIDTH(DATA_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_op;
      pos_r <= in_position;
      val_r <= in_value;
    end
    if (cmd.init_k) begin
      k_r <= is_ins ? count_r : CNT_W'(pos_r);
    end else if (cmd.wr_move) begin
      k_r <= is_ins ? k_m1 : (k_r + CNT_W'(1));
    end
    if (cmd.reply) begin
      status_r <= !ok;
      rdval_r  <= cmd.use_rdata ? ram_rdata : '0;
      ocount_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      strobe_r <= cmd.reply;
    end
  end

  assign out_strobe     = strobe_r;
  assign out_status     = status_r;
  assign out_read_value = rdval_r;
  assign out_count      = ocount_r;

endmodule
